@@ hw/rtl/wnm_pkg.sv @@
// Shared types and constants for the wildcard name matcher.
// No dependencies; imported by the cell row and the top level.
package wnm_pkg;

   // Function codes of an input word
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_NAME   = 2'd2;

   // Character codes with special meaning
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // Per-cycle control broadcast along the cell row
   typedef struct packed {
      logic load_closed; // take the closed next-position bit
      logic restart;     // reload the start-of-name position set
      logic kill;        // leading period: no position survives
   } cell_ctl_type;

endpackage

@@ hw/rtl/wnm_cell.sv @@
// One pattern position: holds a pattern character and its active bit.
// Depends on wnm_pkg for control struct and character codes.
module wnm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wnm_pkg::cell_ctl_type ctl,
   input  logic                  wr_en,
   input  logic [7:0]            char_value,
   input  logic                  used,
   input  logic                  init_val,
   input  logic                  restart_val,
   input  logic                  closed_in,
   input  logic                  adv_in,
   output logic                  adv_out,
   output logic                  raw_out,
   output logic                  prop,
   output logic                  is_star,
   output logic                  is_quest
);
   import wnm_pkg::*;

   logic [7:0] pat_ff;
   logic       act_ff;
   logic       act_in;
   logic       live;
   logic       stay;

   // Classify the stored pattern character
   assign is_star  = (pat_ff == CH_STAR);
   assign is_quest = (pat_ff == CH_QUEST);

   // Stay on a star, advance on a question mark or a literal hit
   assign live    = act_ff & used & ~ctl.kill;
   assign stay    = live & is_star;
   assign adv_out = live & ~is_star & (is_quest | (pat_ff == char_value));
   assign raw_out = stay | adv_in;
   assign prop    = used & is_star;

   // Hold the pattern character once written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_ff <= char_value;
      end
   end

   // Select the next active bit
   always_comb begin
      act_in = act_ff;
      if (ctl.restart) begin
         act_in = restart_val;
      end else if (ctl.load_closed) begin
         act_in = closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= init_val;
      end else begin
         act_ff <= act_in;
      end
   end

endmodule

@@ hw/rtl/wnm_closure.sv @@
// Star closure: spreads each live position across a following run of stars.
// Parallel prefix network, no dependencies.
module wnm_closure #(
   parameter int N = 32
) (
   input  logic [N:0]   gen,
   input  logic [N-1:0] prop,
   output logic [N:0]   closed
);

   localparam int LEVELS = $clog2(N + 1);

   logic [N:0] g_lvl [LEVELS+1];
   logic [N:0] p_lvl [LEVELS+1];

   // Combine spans of doubling length, like a carry lookahead
   always_comb begin
      g_lvl[0] = gen;
      p_lvl[0] = {prop, 1'b0};
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int j = 0; j <= N; j++) begin
            if (j >= (1 << lv)) begin
               g_lvl[lv+1][j] = g_lvl[lv][j] | (p_lvl[lv][j] & g_lvl[lv][j-(1<<lv)]);
               p_lvl[lv+1][j] = p_lvl[lv][j] & p_lvl[lv][j-(1<<lv)];
            end else begin
               g_lvl[lv+1][j] = g_lvl[lv][j];
               p_lvl[lv+1][j] = p_lvl[lv][j];
            end
         end
      end
   end

   assign closed = g_lvl[LEVELS];

endmodule

@@ hw/rtl/wildcard_name_matcher.sv @@
// Wildcard name matcher: a row of pattern cells with a star closure network.
// Result: the verdict for a name is registered when its last character is taken,
// into the skid stage if the output register is still held. Throughput: one word
// per cycle while the skid stage is empty; the active-position update is combinational.
// Reset: empty pattern, only position zero active, overflow clear, output
// empty. The pattern store needs no clearing pass.
module wildcard_name_matcher #(
   parameter int PATTERN_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_value,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);
   import wnm_pkg::*;

   localparam int N  = PATTERN_MAX;
   localparam int LW = $clog2(N + 1);

   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic          start_ff, start_in;
   logic [N:0]    lead_ff, lead_in;
   logic          act_n_ff, act_n_in;

   logic          accept, do_clear, do_append, do_name, full;
   cell_ctl_type  ctl;
   logic [N-1:0]  adv, prop, star_vec, quest_vec;
   logic [N:0]    raw, closed;
   logic          hit;

   logic          out_valid_ff, out_valid_in;
   logic          out_match_ff, out_match_in;
   logic          out_ovf_ff, out_ovf_in;
   logic          skid_valid_ff, skid_valid_in;
   logic          skid_match_ff, skid_match_in;
   logic          skid_ovf_ff, skid_ovf_in;
   logic          push, pop;

   // Decode the accepted word
   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign do_clear  = accept & (req_func == FUNC_CLEAR);
   assign do_append = accept & (req_func == FUNC_APPEND);
   assign do_name   = accept & (req_func == FUNC_NAME);
   assign full      = (len_ff == LW'(N));

   // Block the leading period against a leading wildcard
   assign ctl.kill = start_ff & (req_char_value == CH_DOT) & (len_ff != '0)
                     & (star_vec[0] | quest_vec[0]);
   assign ctl.load_closed = do_name & ~req_last;
   assign ctl.restart     = do_clear | do_append | (do_name & req_last);

   // Cell row
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic adv_left;
      if (i == 0) begin : g_first
         assign adv_left = 1'b0;
      end else begin : g_rest
         assign adv_left = adv[i-1];
      end
      wnm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .wr_en       (do_append & (len_ff == LW'(i))),
         .char_value  (req_char_value),
         .used        (LW'(i) < len_ff),
         .init_val    (i == 0),
         .restart_val (lead_in[i]),
         .closed_in   (closed[i]),
         .adv_in      (adv_left),
         .adv_out     (adv[i]),
         .raw_out     (raw[i]),
         .prop        (prop[i]),
         .is_star     (star_vec[i]),
         .is_quest    (quest_vec[i])
      );
   end
   assign raw[N] = adv[N-1];

   wnm_closure #(.N(N)) u_closure (
      .gen    (raw),
      .prop   (prop),
      .closed (closed)
   );

   // Final position and match decision
   assign hit = closed[len_ff] & ~ovf_ff;

   // Update pattern length, overflow, start-of-name positions
   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      start_in = start_ff;
      lead_in  = lead_ff;
      act_n_in = act_n_ff;
      if (do_clear) begin
         len_in   = '0;
         ovf_in   = 1'b0;
         lead_in  = {{N{1'b0}}, 1'b1};
      end else if (do_append) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + 1'b1;
            for (int j = 1; j <= N; j++) begin
               if (len_ff == LW'(j - 1)) begin
                  lead_in[j] = lead_ff[j-1] & (req_char_value == CH_STAR);
               end
            end
         end
      end
      if (ctl.restart) begin
         start_in = 1'b1;
         act_n_in = lead_in[N];
      end else if (ctl.load_closed) begin
         start_in = 1'b0;
         act_n_in = closed[N];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         start_ff <= 1'b1;
         lead_ff  <= {{N{1'b0}}, 1'b1};
         act_n_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         start_ff <= start_in;
         lead_ff  <= lead_in;
         act_n_ff <= act_n_in;
      end
   end

   // Output register with skid stage
   assign push = do_name & req_last;
   assign pop  = out_valid_ff & rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_match_in  = out_match_ff;
      out_ovf_in    = out_ovf_ff;
      skid_valid_in = skid_valid_ff;
      skid_match_in = skid_match_ff;
      skid_ovf_in   = skid_ovf_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_match_in  = skid_match_ff;
            out_ovf_in    = skid_ovf_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (~out_valid_ff | pop) begin
            out_valid_in = 1'b1;
            out_match_in = hit;
            out_ovf_in   = ovf_ff;
         end else begin
            skid_valid_in = 1'b1;
            skid_match_in = hit;
            skid_ovf_in   = ovf_ff;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold result payloads
   always_ff @(posedge clock) begin
      out_match_ff  <= out_match_in;
      out_ovf_ff    <= out_ovf_in;
      skid_match_ff <= skid_match_in;
      skid_ovf_ff   <= skid_ovf_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_matched          = out_match_ff;
   assign rsp_pattern_overflow = out_ovf_ff;

endmodule

@@ tb/tb_wildcard_name_matcher.sv @@
// Testbench for wildcard_name_matcher: directed and random pattern/name words
// checked against an in-bench prediction of the active-position set.
// Depends on wnm_pkg and the wildcard_name_matcher top level.
`timescale 1ns / 100ps

module tb_wildcard_name_matcher;
   import wnm_pkg::*;

   localparam int PATTERN_MAX = 32;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_WORDS = 740;
   localparam int STEADY_WORDS = 150;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_CLEAR;
   logic [7:0] req_char_value = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   // Predicted matcher state
   logic [7:0]           pat_chars [PATTERN_MAX];
   int unsigned          pat_len = 0;
   logic [PATTERN_MAX:0] live_pos = 1;
   bit                   name_start = 1'b1;
   bit                   pat_overflow = 1'b0;

   verdict_type pending_verdicts[$];
   logic [7:0]  cur_pattern[$];
   logic [7:0]  cur_name[$];

   int  words_sent = 0;
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  send_idle_on = 1'b1;
   bit  recv_idle_on = 1'b1;
   bit  hold_long = 1'b0;

   wildcard_name_matcher dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_char_value      (req_char_value),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_matched         (rsp_matched),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   always #5 clock = ~clock;

   // Let every live star also match nothing
   function automatic logic [PATTERN_MAX:0] star_closure(input logic [PATTERN_MAX:0] set);
      int i;
      for (i = 0; i < pat_len && i < PATTERN_MAX; i++) begin
         if (set[i] && pat_chars[i] == CH_STAR) set[i+1] = 1'b1;
      end
      return set;
   endfunction

   function automatic void restart_name();
      live_pos   = 1;
      name_start = 1'b1;
   endfunction

   // Advance the predicted state by one accepted word
   function automatic void predict_word(input logic [1:0] func, input logic [7:0] ch,
                                        input logic last);
      logic [PATTERN_MAX:0] cur;
      logic [PATTERN_MAX:0] nxt;
      verdict_type v;
      int i;
      case (func)
         FUNC_CLEAR: begin
            pat_len      = 0;
            pat_overflow = 1'b0;
            restart_name();
         end
         FUNC_APPEND: begin
            if (pat_len < PATTERN_MAX) begin
               pat_chars[pat_len] = ch;
               pat_len++;
            end else begin
               pat_overflow = 1'b1;
            end
            restart_name();
         end
         FUNC_NAME: begin
            cur = star_closure(live_pos);
            nxt = '0;
            // a leading period is never matched by a wildcard
            if (!(name_start && ch == CH_DOT && pat_len > 0 &&
                  (pat_chars[0] == CH_STAR || pat_chars[0] == CH_QUEST))) begin
               for (i = 0; i < pat_len && i < PATTERN_MAX; i++) begin
                  if (cur[i]) begin
                     if (pat_chars[i] == CH_STAR) nxt[i] = 1'b1;
                     else if (pat_chars[i] == CH_QUEST || pat_chars[i] == ch) nxt[i+1] = 1'b1;
                  end
               end
            end
            live_pos   = star_closure(nxt);
            name_start = 1'b0;
            if (last) begin
               v.matched  = live_pos[pat_len] && !pat_overflow;
               v.overflow = pat_overflow;
               pending_verdicts.push_back(v);
               restart_name();
            end
         end
         default: ;
      endcase
   endfunction

   // Offer one word, with an optional idle burst first, and hold until taken
   task automatic send_word(input logic [1:0] func, input logic [7:0] ch, input logic last);
      if (send_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid      <= 1'b0;
         req_func       <= 2'($urandom_range(0, 3));
         req_char_value <= 8'($urandom_range(0, 255));
         req_last       <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_char_value <= ch;
      req_last       <= last;
      do @(posedge clock); while (!req_ready);
      predict_word(func, ch, last);
      words_sent++;
   endtask

   function automatic logic [7:0] pick_pattern_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return CH_STAR;
      if (r < 35) return CH_QUEST;
      if (r < 50) return "a";
      if (r < 65) return "b";
      if (r < 75) return CH_DOT;
      if (r < 80) return CH_BRACKET;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_name_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return "a";
      if (r < 65) return "b";
      if (r < 72) return CH_DOT;
      if (r < 77) return CH_BRACKET;
      if (r < 82) return CH_STAR;
      if (r < 87) return CH_QUEST;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic load_pattern(input int len);
      logic [7:0] c;
      send_word(FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      cur_pattern.delete();
      repeat (len) begin
         c = pick_pattern_char();
         cur_pattern.push_back(c);
         send_word(FUNC_APPEND, c, 1'($urandom_range(0, 1)));
      end
   endtask

   // Build a name that mostly follows the current pattern
   function automatic void build_name();
      int i;
      cur_name.delete();
      if ($urandom_range(0, 9) == 0) cur_name.push_back(CH_DOT);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 8)) cur_name.push_back(pick_name_char());
      end else begin
         foreach (cur_pattern[i]) begin
            if (cur_pattern[i] == CH_STAR) begin
               repeat ($urandom_range(0, 3)) cur_name.push_back(pick_name_char());
            end else if (cur_pattern[i] == CH_QUEST) begin
               cur_name.push_back(pick_name_char());
            end else begin
               cur_name.push_back(cur_pattern[i]);
            end
         end
         if (cur_name.size() > 0 && $urandom_range(0, 4) == 0) begin
            i = $urandom_range(0, cur_name.size() - 1);
            cur_name[i] = pick_name_char();
         end
      end
      if (cur_name.size() == 0) cur_name.push_back(pick_name_char());
   endfunction

   // Send the current name, with stray unused words and the odd broken name
   task automatic send_name();
      int i;
      int cut;
      cut = cur_name.size();
      if ($urandom_range(0, 24) == 0) cut = $urandom_range(0, cur_name.size() - 1);
      for (i = 0; i < cut; i++) begin
         if ($urandom_range(0, 39) == 0) begin
            send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         send_word(FUNC_NAME, cur_name[i], i == cur_name.size() - 1);
      end
      // a broken name may be cut off by a pattern change
      if (cut < cur_name.size() && $urandom_range(0, 1) == 0) begin
         cur_pattern.push_back(pick_pattern_char());
         send_word(FUNC_APPEND, cur_pattern[$], 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_round();
      int r;
      int len;
      r = $urandom_range(0, 19);
      if (r == 0) len = 0;
      else if (r == 1) len = $urandom_range(28, 34);
      else len = $urandom_range(1, 6);
      load_pattern(len);
      repeat ($urandom_range(2, 6)) begin
         build_name();
         send_name();
      end
   endtask

   task automatic test_empty_pattern();
      send_word(FUNC_CLEAR, 8'hFF, 1'b1);
      send_word(FUNC_NAME, "a", 1'b1);
      send_word(FUNC_NAME, 8'h00, 1'b1);
   endtask

   task automatic test_star_and_leading_period();
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      send_word(FUNC_APPEND, CH_STAR, 1'b0);
      send_word(FUNC_NAME, CH_DOT, 1'b1);
      send_word(FUNC_NAME, "x", 1'b1);
      send_word(FUNC_NAME, CH_DOT, 1'b0);
      send_word(FUNC_UNUSED, 8'hA5, 1'b1);
      send_word(FUNC_NAME, "a", 1'b1);
   endtask

   task automatic test_trailing_star();
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      send_word(FUNC_APPEND, "a", 1'b0);
      send_word(FUNC_APPEND, CH_STAR, 1'b1);
      send_word(FUNC_NAME, "a", 1'b1);
   endtask

   task automatic test_question_bracket_extremes();
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      send_word(FUNC_APPEND, CH_QUEST, 1'b0);
      send_word(FUNC_APPEND, CH_BRACKET, 1'b0);
      send_word(FUNC_APPEND, 8'hFF, 1'b0);
      send_word(FUNC_NAME, 8'h00, 1'b0);
      send_word(FUNC_NAME, CH_BRACKET, 1'b0);
      send_word(FUNC_NAME, 8'hFF, 1'b1);
   endtask

   task automatic test_abandoned_name();
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      send_word(FUNC_APPEND, "a", 1'b0);
      send_word(FUNC_NAME, "a", 1'b0);
      send_word(FUNC_APPEND, "b", 1'b0);
      send_word(FUNC_NAME, "a", 1'b0);
      send_word(FUNC_NAME, "b", 1'b1);
   endtask

   task automatic test_pattern_overflow();
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      repeat (PATTERN_MAX + 1) send_word(FUNC_APPEND, "a", 1'b0);
      repeat (PATTERN_MAX - 1) send_word(FUNC_NAME, "a", 1'b0);
      send_word(FUNC_NAME, "a", 1'b1);
      // clear drops the overflow flag again
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      send_word(FUNC_APPEND, "a", 1'b0);
      send_word(FUNC_NAME, "a", 1'b1);
   endtask

   task automatic test_random_names();
      while (words_sent < RANDOM_WORDS) begin
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         random_round();
      end
   endtask

   // Hold the receiver off long enough for the block to stall its input
   task automatic test_output_backpressure();
      send_word(FUNC_CLEAR, 8'h00, 1'b0);
      send_word(FUNC_APPEND, CH_STAR, 1'b0);
      hold_long = 1'b1;
      repeat (40) send_word(FUNC_NAME, pick_name_char(), 1'b1);
      while (hold_long) @(posedge clock);
   endtask

   task automatic test_steady_stream();
      int target;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      target = words_sent + STEADY_WORDS;
      while (words_sent < target) random_round();
   endtask

   // Receiver: random ready bursts, plus one long hold on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
            rsp_ready <= 1'b1;
         end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Compare each taken result word with the oldest predicted verdict
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word matched=%0b overflow=%0b",
                     $time, rsp_matched, rsp_pattern_overflow);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_matched !== want.matched) begin
               error_count++;
               $display("%0t: matched expected %0b actual %0b",
                        $time, want.matched, rsp_matched);
            end
            if (rsp_pattern_overflow !== want.overflow) begin
               error_count++;
               $display("%0t: pattern_overflow expected %0b actual %0b",
                        $time, want.overflow, rsp_pattern_overflow);
            end
         end
      end
   end

   // Drop the run when no word moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_pattern();
      test_star_and_leading_period();
      test_trailing_star();
      test_question_bracket_extremes();
      test_abandoned_name();
      test_pattern_overflow();
      test_random_names();
      test_output_backpressure();
      test_steady_stream();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
